[sv/scd_pkg.sv]
// shared types and constants for the sparse constraint distribute core
// operation codes, controller states and fixed field widths; no dependencies
`timescale 1ns / 1ps
`default_nettype none

package scd_pkg;

  localparam int unsigned OP_W        = 3;
  localparam int unsigned IDX_W       = 12;
  localparam int unsigned VAL_W       = 32;
  localparam int unsigned COEF_W      = 18;
  localparam int unsigned ACC_W       = 48;
  localparam int unsigned PROD_W      = VAL_W + COEF_W;
  localparam int unsigned TERM_W      = PROD_W - 16;
  // wide enough to compare any index against the largest supported depth
  localparam int unsigned IDX_EXT_W   = 21;
  localparam int unsigned IN_DATA_W   = 80;
  localparam int unsigned DEFAULT_VECTOR_DEPTH = 4096;

  typedef enum logic [OP_W-1:0] {
    OP_WRITE      = 3'd0,
    OP_READ       = 3'd1,
    OP_DISTRIBUTE = 3'd2,
    OP_CONDENSE   = 3'd3,
    OP_ZERO_ROW   = 3'd4
  } op_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_LATCH_ROW,
    S_MUL,
    S_ACC,
    S_CLEAR,
    S_DONE
  } state_t;

endpackage

`default_nettype wire

[sv/sparse_constraint_distribute_core.sv]
// sparse constraint distribute core: vector store with affine constraint rows
// applied one term per transaction; depends on scd_pkg
`timescale 1ns / 1ps
`default_nettype none

// channel  dir  signals                       contents
// s        in   s_tvalid s_tready s_tdata     tdata: operation, row, column, value, coef
//                s_tuser s_tlast              tuser: first_term, no_term; tlast: last_term
// m        out  m_tvalid m_tready m_tdata     tdata: read_value
//                m_tuser m_tlast              tuser: saturated; tlast: row_done
//
// one transaction in flight at a time: write, zero row, no-term and unused codes go from
// decode to done, read through the row latch state, distribute and condense terms through
// multiply and accumulate (a first condense term reads its row first, a last one clears it)
// the order is set by the registered memory read and the registered multiply stage
// rst is synchronous; it clears control, the row accumulator and the latched slave value
// a result waiting on m_tready holds the block in its done state; input is taken again
// once the output register has room
module sparse_constraint_distribute_core
  import scd_pkg::*;
#(
  parameter int unsigned VECTOR_DEPTH = DEFAULT_VECTOR_DEPTH
) (
  input  wire logic                 clk,
  input  wire logic                 rst,
  input  wire logic                 s_tvalid,
  output logic                      s_tready,
  // [2:0] operation, [14:3] row_index, [26:15] column_index,
  // [58:27] value, [76:59] coefficient, [79:77] zero
  input  wire logic [IN_DATA_W-1:0] s_tdata,
  // [0] first_term, [1] no_term
  input  wire logic [1:0]           s_tuser,
  input  wire logic                 s_tlast,
  output logic                      m_tvalid,
  input  wire logic                 m_tready,
  // [31:0] read_value
  output logic [VAL_W-1:0]          m_tdata,
  // [0] saturated
  output logic                      m_tuser,
  output logic                      m_tlast
);

  localparam int unsigned ADDR_W = $clog2(VECTOR_DEPTH);
  localparam logic [IDX_EXT_W-1:0] DEPTH_EXT = IDX_EXT_W'(VECTOR_DEPTH);
  localparam logic signed [ACC_W-1:0] ACC_MAX = {1'b0, {(ACC_W-1){1'b1}}};
  localparam logic signed [ACC_W-1:0] ACC_MIN = {1'b1, {(ACC_W-1){1'b0}}};
  localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};
  localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};

  state_t state, state_next;

  // captured item
  logic [OP_W-1:0]          op;
  logic [IDX_W-1:0]         row;
  logic [IDX_W-1:0]         col;
  logic signed [VAL_W-1:0]  val;
  logic signed [COEF_W-1:0] coef;
  logic                     first;
  logic                     last;
  logic                     none;

  logic signed [ACC_W-1:0]  acc;
  logic signed [VAL_W-1:0]  slave;
  logic signed [VAL_W-1:0]  colval;
  logic signed [PROD_W-1:0] product;
  logic [VAL_W-1:0]         res_value;
  logic                     res_done;
  logic                     sat;

  // vector memory
  logic [VAL_W-1:0]  mem [VECTOR_DEPTH];
  logic [VAL_W-1:0]  rd_data;
  logic              rd_en;
  logic [ADDR_W-1:0] rd_addr;
  logic              mem_we;
  logic [ADDR_W-1:0] wr_addr;
  logic [VAL_W-1:0]  wr_data;

  logic [IDX_EXT_W-1:0] row_ext, col_ext;
  logic                 row_ok, col_ok;
  logic [ADDR_W-1:0]    row_addr, col_addr;

  logic                     in_accept;
  logic                     out_load;
  logic signed [VAL_W-1:0]  mul_operand;
  logic signed [PROD_W-1:0] prod_rounded;
  logic signed [TERM_W-1:0] term;
  logic signed [ACC_W:0]    acc_base, acc_sum;
  logic                     acc_ovf;
  logic signed [ACC_W-1:0]  acc_clip;
  logic                     res_ovf;
  logic signed [VAL_W-1:0]  res_clip;
  logic signed [VAL_W+3:0]  cond_sum;
  logic                     cond_ovf;
  logic signed [VAL_W-1:0]  cond_clip;

  assign in_accept = s_tvalid && s_tready;
  assign s_tready  = (state == S_IDLE);
  assign out_load  = (state == S_DONE) && (!m_tvalid || m_tready);

  assign row_ext  = IDX_EXT_W'(row);
  assign col_ext  = IDX_EXT_W'(col);
  assign row_ok   = row_ext < DEPTH_EXT;
  assign col_ok   = col_ext < DEPTH_EXT;
  assign row_addr = row_ext[ADDR_W-1:0];
  assign col_addr = col_ext[ADDR_W-1:0];

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  // arithmetic
  assign mul_operand  = (op == OP_DISTRIBUTE) ? (col_ok ? signed'(rd_data) : '0) : slave;
  // round half up: add half an lsb, then floor by arithmetic shift
  assign prod_rounded = product + PROD_W'(32768);
  assign term         = prod_rounded[PROD_W-1:16];

  assign acc_base = first ? {{(ACC_W+1-VAL_W){val[VAL_W-1]}}, val} : {acc[ACC_W-1], acc};
  assign acc_sum  = acc_base + {{(ACC_W+1-TERM_W){term[TERM_W-1]}}, term};
  assign acc_ovf  = acc_sum[ACC_W] ^ acc_sum[ACC_W-1];
  assign acc_clip = acc_ovf ? (acc_sum[ACC_W] ? ACC_MIN : ACC_MAX) : acc_sum[ACC_W-1:0];

  assign res_ovf  = !((&acc_clip[ACC_W-1:VAL_W-1]) || !(|acc_clip[ACC_W-1:VAL_W-1]));
  assign res_clip = res_ovf ? (acc_clip[ACC_W-1] ? VAL_MIN : VAL_MAX)
                            : acc_clip[VAL_W-1:0];

  assign cond_sum  = {{4{colval[VAL_W-1]}}, colval}
                   + {{(VAL_W+4-TERM_W){term[TERM_W-1]}}, term};
  assign cond_ovf  = !((&cond_sum[VAL_W+3:VAL_W-1]) || !(|cond_sum[VAL_W+3:VAL_W-1]));
  assign cond_clip = cond_ovf ? (cond_sum[VAL_W+3] ? VAL_MIN : VAL_MAX)
                              : cond_sum[VAL_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    rd_en      = 1'b0;
    rd_addr    = row_addr;
    mem_we     = 1'b0;
    wr_addr    = row_addr;
    wr_data    = '0;
    case (state)
      S_IDLE: begin
        if (in_accept) begin
          state_next = S_DECODE;
        end
      end
      S_DECODE: begin
        state_next = S_DONE;
        case (op)
          OP_WRITE: begin
            mem_we  = row_ok;
            wr_data = val;
          end
          OP_READ: begin
            rd_en      = 1'b1;
            state_next = S_LATCH_ROW;
          end
          OP_DISTRIBUTE: begin
            if (none) begin
              mem_we  = row_ok;
              wr_data = val;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = col_addr;
              state_next = S_MUL;
            end
          end
          OP_CONDENSE: begin
            if (none) begin
              mem_we = row_ok;
            end else if (first) begin
              rd_en      = 1'b1;
              state_next = S_LATCH_ROW;
            end else begin
              rd_en      = 1'b1;
              rd_addr    = col_addr;
              state_next = S_MUL;
            end
          end
          OP_ZERO_ROW: begin
            mem_we = row_ok;
          end
          default: begin
          end
        endcase
      end
      S_LATCH_ROW: begin
        if (op == OP_READ) begin
          state_next = S_DONE;
        end else begin
          rd_en      = 1'b1;
          rd_addr    = col_addr;
          state_next = S_MUL;
        end
      end
      S_MUL: begin
        state_next = S_ACC;
      end
      S_ACC: begin
        if (op == OP_DISTRIBUTE) begin
          mem_we     = last && row_ok;
          wr_data    = res_clip;
          state_next = S_DONE;
        end else begin
          mem_we     = col_ok;
          wr_addr    = col_addr;
          wr_data    = cond_clip;
          state_next = last ? S_CLEAR : S_DONE;
        end
      end
      S_CLEAR: begin
        mem_we     = row_ok;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (out_load) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      acc      <= '0;
      slave    <= '0;
      m_tvalid <= 1'b0;
    end else begin
      if (out_load) begin
        m_tvalid <= 1'b1;
        m_tdata  <= res_value;
        m_tlast  <= res_done;
        m_tuser  <= sat;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_accept) begin
            op        <= s_tdata[2:0];
            row       <= s_tdata[14:3];
            col       <= s_tdata[26:15];
            val       <= s_tdata[58:27];
            coef      <= s_tdata[76:59];
            first     <= s_tuser[0];
            none      <= s_tuser[1];
            last      <= s_tlast;
            res_value <= '0;
            res_done  <= 1'b0;
            sat       <= 1'b0;
          end
        end
        S_DECODE: begin
          if (none && (op == OP_DISTRIBUTE)) begin
            res_value <= val;
            res_done  <= 1'b1;
          end else if ((none && (op == OP_CONDENSE)) || (op == OP_ZERO_ROW)) begin
            res_done <= 1'b1;
          end
        end
        S_LATCH_ROW: begin
          if (op == OP_READ) begin
            res_value <= row_ok ? rd_data : '0;
          end else begin
            slave <= row_ok ? signed'(rd_data) : '0;
          end
        end
        S_MUL: begin
          colval  <= col_ok ? signed'(rd_data) : '0;
          product <= mul_operand * coef;
        end
        S_ACC: begin
          if (op == OP_DISTRIBUTE) begin
            acc <= acc_clip;
            if (last) begin
              res_value <= res_clip;
              res_done  <= 1'b1;
              sat       <= sat | acc_ovf | res_ovf;
            end else begin
              sat <= sat | acc_ovf;
            end
          end else begin
            sat <= sat | cond_ovf;
            if (last) begin
              res_done <= 1'b1;
            end
          end
        end
        default: begin
        end
      endcase
    end
  end

  // one transaction at a time: no second accept right behind the first
  a_single_item: assert property (@(posedge clk) disable iff (rst)
    in_accept |=> !s_tready)
    else $error("input accepted while an item is in progress");

  // the memory is never written while the block waits for input
  a_no_idle_write: assert property (@(posedge clk) disable iff (rst)
    (state == S_IDLE) |-> !mem_we)
    else $error("memory write while idle");

  // a new result only appears out of the done state
  a_result_source: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !$past(m_tvalid) && !$past(rst)) |-> $past(state == S_DONE))
    else $error("result presented without a finished item");

  // a stalled result keeps the block from taking more input
  a_stall_blocks: assert property (@(posedge clk) disable iff (rst)
    ((state == S_DONE) && m_tvalid && !m_tready) |=> !s_tready)
    else $error("input taken while the result slot is full");

endmodule

`default_nettype wire

[sim/tb_top.sv]
// self-checking bench for sparse_constraint_distribute_core: directed table, a long
// accumulator run and random constraint rows; most table rows carry their own expected
// results, the rest is checked against an in-bench predictor; depends on scd_pkg and the core
`timescale 1ns / 1ps

module tb_top;
  import scd_pkg::*;

  localparam int unsigned DEPTH      = DEFAULT_VECTOR_DEPTH;
  localparam int unsigned CYCLE_CAP  = 1_000_000;
  localparam int unsigned DRAIN_WAIT = 20;
  localparam int unsigned SAT_TERMS  = 24;

  // codes the core leaves without effect
  localparam logic [OP_W-1:0] OP_RSVD5 = 3'd5;
  localparam logic [OP_W-1:0] OP_RSVD6 = 3'd6;
  localparam logic [OP_W-1:0] OP_RSVD7 = 3'd7;

  localparam longint ACC_HI = 64'sh0000_7FFF_FFFF_FFFF;
  localparam longint ACC_LO = -ACC_HI - 1;
  localparam longint Q16_HI = 64'sd2147483647;
  localparam longint Q16_LO = -64'sd2147483648;

  typedef struct packed {
    logic [OP_W-1:0]   op;
    logic [IDX_W-1:0]  row;
    logic [IDX_W-1:0]  col;
    logic [VAL_W-1:0]  value;
    logic [COEF_W-1:0] coef;
    logic              first;
    logic              last;
    logic              none;
  } term_item_t;

  typedef struct packed {
    logic [VAL_W-1:0] rv;
    logic             done;
    logic             sat;
  } row_result_t;

  typedef struct packed {
    term_item_t  it;
    logic        typed;
    row_result_t res;
  } table_row_t;

  logic                 clk = 1'b0;
  logic                 rst = 1'b1;
  logic                 s_tvalid = 1'b0;
  logic                 s_tready;
  // [2:0] operation, [14:3] row_index, [26:15] column_index,
  // [58:27] value, [76:59] coefficient, [79:77] zero
  logic [IN_DATA_W-1:0] s_tdata = '0;
  // [0] first_term, [1] no_term
  logic [1:0]           s_tuser = '0;
  logic                 s_tlast = 1'b0;
  logic                 m_tvalid;
  logic                 m_tready = 1'b0;
  // [31:0] read_value
  logic [VAL_W-1:0]     m_tdata;
  // [0] saturated
  logic                 m_tuser;
  logic                 m_tlast;

  sparse_constraint_distribute_core #(
    .VECTOR_DEPTH(DEPTH)
  ) u_top (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .s_tlast  (s_tlast),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

  // predictor state
  logic [VAL_W-1:0] vec_model [DEPTH];
  bit               vec_valid [DEPTH];
  int unsigned      loaded_idx [$];
  longint           acc_model = 0;
  logic [VAL_W-1:0] slave_model = '0;

  row_result_t      pending_results [$];
  table_row_t       directed_tab [$];
  int unsigned      mismatch_count = 0;
  int unsigned      cycle_count = 0;
  int unsigned      tx_idle_pct = 0;
  int unsigned      rx_idle_pct = 0;

  initial begin
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_CAP) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  always @(posedge clk) begin
    m_tready <= (rx_idle_pct == 0) || ($urandom_range(0, 99) >= rx_idle_pct);
  end

  function automatic void note_error(input string msg);
    mismatch_count++;
    if (mismatch_count <= 10) $display("error: %s", msg);
  endfunction

  always @(posedge clk) begin : result_monitor
    row_result_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (pending_results.size() == 0) begin
        note_error($sformatf("unexpected result rv=%h done=%b sat=%b",
                             m_tdata, m_tlast, m_tuser));
      end else begin
        want = pending_results.pop_front();
        if (m_tdata !== want.rv || m_tlast !== want.done || m_tuser !== want.sat)
          note_error($sformatf("rv exp %h got %h, done exp %b got %b, sat exp %b got %b",
                               want.rv, m_tdata, want.done, m_tlast, want.sat, m_tuser));
      end
    end
  end

  function automatic void vec_put(input logic [IDX_W-1:0] idx, input logic [VAL_W-1:0] v);
    vec_model[idx] = v;
    if (!vec_valid[idx]) begin
      vec_valid[idx] = 1'b1;
      loaded_idx = {loaded_idx, 32'(idx)};
    end
  endfunction

  // q16.16 times q2.16, half lsb added then floored
  function automatic longint round_product(input logic [VAL_W-1:0] x,
                                           input logic [COEF_W-1:0] c);
    longint p;
    p = longint'($signed(x)) * longint'($signed(c)) + 64'sd32768;
    return p >>> 16;
  endfunction

  function automatic logic [VAL_W-1:0] clip_q16(input longint v, inout logic sat);
    if (v > Q16_HI) begin
      sat = 1'b1;
      return Q16_HI[VAL_W-1:0];
    end
    if (v < Q16_LO) begin
      sat = 1'b1;
      return Q16_LO[VAL_W-1:0];
    end
    return v[VAL_W-1:0];
  endfunction

  function automatic row_result_t apply_constraint_item(input term_item_t it);
    row_result_t r;
    longint      sum;
    r = '0;
    case (it.op)
      OP_WRITE: vec_put(it.row, it.value);
      OP_READ:  r.rv = vec_model[it.row];
      OP_DISTRIBUTE: begin
        if (it.none) begin
          vec_put(it.row, it.value);
          r.rv   = it.value;
          r.done = 1'b1;
        end else begin
          sum = (it.first ? longint'($signed(it.value)) : acc_model) +
                round_product(vec_model[it.col], it.coef);
          if (sum > ACC_HI) begin
            sum   = ACC_HI;
            r.sat = 1'b1;
          end else if (sum < ACC_LO) begin
            sum   = ACC_LO;
            r.sat = 1'b1;
          end
          acc_model = sum;
          if (it.last) begin
            r.rv = clip_q16(acc_model, r.sat);
            vec_put(it.row, r.rv);
            r.done = 1'b1;
          end
        end
      end
      OP_CONDENSE: begin
        if (it.none) begin
          vec_put(it.row, '0);
          r.done = 1'b1;
        end else begin
          if (it.first) slave_model = vec_model[it.row];
          sum = longint'($signed(vec_model[it.col])) + round_product(slave_model, it.coef);
          vec_put(it.col, clip_q16(sum, r.sat));
          if (it.last) begin
            vec_put(it.row, '0);
            r.done = 1'b1;
          end
        end
      end
      OP_ZERO_ROW: begin
        vec_put(it.row, '0);
        r.done = 1'b1;
      end
      default: ;
    endcase
    return r;
  endfunction

  function automatic term_item_t mk_term(input logic [OP_W-1:0] op,
                                         input logic [IDX_W-1:0] row,
                                         input logic [IDX_W-1:0] col,
                                         input logic [VAL_W-1:0] value,
                                         input logic [COEF_W-1:0] coef,
                                         input int unsigned first,
                                         input int unsigned last,
                                         input int unsigned none);
    term_item_t t;
    t.op    = op;
    t.row   = row;
    t.col   = col;
    t.value = value;
    t.coef  = coef;
    t.first = first[0];
    t.last  = last[0];
    t.none  = none[0];
    return t;
  endfunction

  function automatic void tab_add(input term_item_t it, input int unsigned typed,
                                  input logic [VAL_W-1:0] rv, input int unsigned done,
                                  input int unsigned sat);
    table_row_t e;
    e.it       = it;
    e.typed    = typed[0];
    e.res.rv   = rv;
    e.res.done = done[0];
    e.res.sat  = sat[0];
    directed_tab = {directed_tab, e};
  endfunction

  task automatic send_term(input term_item_t it, input logic typed = 1'b0,
                           input row_result_t fixed = '0);
    row_result_t predicted;
    while (tx_idle_pct != 0 && $urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {3'b000, it.coef, it.value, it.col, it.row, it.op};
    s_tuser  <= {it.none, it.first};
    s_tlast  <= it.last;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = apply_constraint_item(it);
    pending_results = {pending_results, (typed ? fixed : predicted)};
  endtask

  function automatic logic [IDX_W-1:0] loaded_index();
    return IDX_W'(loaded_idx[$urandom_range(0, loaded_idx.size() - 1)]);
  endfunction

  function automatic logic [IDX_W-1:0] any_index();
    return IDX_W'($urandom_range(0, DEPTH - 1));
  endfunction

  function automatic logic [VAL_W-1:0] rand_q16();
    case ($urandom_range(0, 7))
      0:       return 32'h7FFF_FFFF;
      1:       return 32'h8000_0000;
      2:       return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
      default: return $urandom();
    endcase
  endfunction

  function automatic logic [COEF_W-1:0] rand_coef();
    case ($urandom_range(0, 7))
      0:       return 18'h1FFFF;
      1:       return 18'h20000;
      2:       return COEF_W'($urandom_range(0, 18'h20000) - 18'h10000);
      default: return COEF_W'($urandom());
    endcase
  endfunction

  task automatic run_random_phase(input int unsigned n_items, input int unsigned tx_pct,
                                  input int unsigned rx_pct);
    int unsigned      start;
    int unsigned      kind;
    int unsigned      len;
    logic [IDX_W-1:0] r;
    logic [OP_W-1:0]  op;
    start       = pending_results.size();
    tx_idle_pct = tx_pct;
    rx_idle_pct = rx_pct;
    start = 0;
    while (start < n_items) begin
      kind = $urandom_range(0, 99);
      if (kind < 10) begin
        send_term(mk_term(OP_WRITE, any_index(), any_index(), rand_q16(), rand_coef(),
                          $urandom(), $urandom(), $urandom()));
        start++;
      end else if (kind < 18) begin
        send_term(mk_term(OP_READ, loaded_index(), any_index(), rand_q16(), rand_coef(),
                          $urandom(), $urandom(), $urandom()));
        start++;
      end else if (kind < 48) begin
        // well-formed distribute row
        len = $urandom_range(1, 4);
        r   = any_index();
        for (int unsigned k = 0; k < len; k++)
          send_term(mk_term(OP_DISTRIBUTE, r, loaded_index(), rand_q16(), rand_coef(),
                            32'(k == 0), 32'(k == len - 1), 0));
        start += len;
      end else if (kind < 73) begin
        // well-formed condense row
        len = $urandom_range(1, 4);
        r   = loaded_index();
        for (int unsigned k = 0; k < len; k++)
          send_term(mk_term(OP_CONDENSE, r, loaded_index(), rand_q16(), rand_coef(),
                            32'(k == 0), 32'(k == len - 1), 0));
        start += len;
      end else if (kind < 80) begin
        op = $urandom_range(0, 1) ? OP_DISTRIBUTE : OP_CONDENSE;
        send_term(mk_term(op, any_index(), any_index(), rand_q16(), rand_coef(),
                          $urandom(), $urandom(), 1));
        start++;
      end else if (kind < 85) begin
        send_term(mk_term(OP_ZERO_ROW, any_index(), any_index(), rand_q16(), rand_coef(),
                          $urandom(), $urandom(), $urandom()));
        start++;
      end else if (kind < 95) begin
        // broken row framing
        op = $urandom_range(0, 1) ? OP_DISTRIBUTE : OP_CONDENSE;
        send_term(mk_term(op, loaded_index(), loaded_index(), rand_q16(), rand_coef(),
                          $urandom(), $urandom(), 0));
        start++;
      end else begin
        op = OP_W'($urandom_range(OP_RSVD5, OP_RSVD7));
        send_term(mk_term(op, any_index(), any_index(), $urandom(), COEF_W'($urandom()),
                          $urandom(), $urandom(), $urandom()));
        start++;
      end
    end
  endtask

  initial begin
    // extremes, rounding, framing and no-effect codes
    tab_add(mk_term(OP_WRITE, 12'd0, 12'd0, 32'h7FFF_FFFF, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_WRITE, 12'd4095, 12'd0, 32'h8000_0000, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_WRITE, 12'd1, 12'd0, 32'h0001_0000, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_READ, 12'd0, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h7FFF_FFFF, 0, 0);
    tab_add(mk_term(OP_READ, 12'd4095, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h8000_0000, 0, 0);
    // condense with no first term after reset uses a zero slave value
    tab_add(mk_term(OP_CONDENSE, 12'd4095, 12'd1, 32'h0, 18'h1FFFF, 0, 0, 0), 1, 32'h0, 0, 0);
    // distribute with no first term starts from the reset accumulator
    tab_add(mk_term(OP_DISTRIBUTE, 12'd5, 12'd1, 32'h0, 18'h10000, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd5, 12'd1, 32'h0, 18'h10000, 0, 1, 0),
            1, 32'h0002_0000, 1, 0);
    tab_add(mk_term(OP_READ, 12'd5, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h0002_0000, 0, 0);
    // row end clipped to the q16.16 range, both signs
    tab_add(mk_term(OP_DISTRIBUTE, 12'd6, 12'd0, 32'h7FFF_FFFF, 18'h1FFFF, 1, 1, 0),
            1, 32'h7FFF_FFFF, 1, 1);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd7, 12'd4095, 32'h8000_0000, 18'h1FFFF, 1, 1, 0),
            1, 32'h8000_0000, 1, 1);
    // condense update clipped, then a term whose column is its own row
    tab_add(mk_term(OP_CONDENSE, 12'd1, 12'd0, 32'h0, 18'h10000, 1, 0, 0), 1, 32'h0, 0, 1);
    tab_add(mk_term(OP_CONDENSE, 12'd1, 12'd1, 32'h0, 18'h10000, 0, 1, 0), 1, 32'h0, 1, 0);
    tab_add(mk_term(OP_READ, 12'd1, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_READ, 12'd0, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h7FFF_FFFF, 0, 0);
    // no-term items ignore the framing flags
    tab_add(mk_term(OP_CONDENSE, 12'd0, 12'd0, 32'h1111_1111, 18'h0, 1, 1, 1), 1, 32'h0, 1, 0);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd8, 12'd0, 32'h1234_5678, 18'h0, 1, 0, 1),
            1, 32'h1234_5678, 1, 0);
    tab_add(mk_term(OP_ZERO_ROW, 12'd4095, 12'd0, 32'hFFFF_FFFF, 18'h0, 0, 0, 0),
            1, 32'h0, 1, 0);
    tab_add(mk_term(OP_READ, 12'd4095, 12'd0, 32'h0, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    // half an lsb rounds up for either sign, then a predictor-checked row and the no-effect codes
    tab_add(mk_term(OP_WRITE, 12'd10, 12'd0, 32'h0000_0001, 18'h0, 0, 0, 0), 1, 32'h0, 0, 0);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd11, 12'd10, 32'h0, 18'h08000, 1, 1, 0),
            1, 32'h0000_0001, 1, 0);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd11, 12'd10, 32'h0, 18'h38000, 1, 1, 0),
            1, 32'h0, 1, 0);
    tab_add(mk_term(OP_DISTRIBUTE, 12'd9, 12'd8, 32'hDEAD_BEEF, 18'h20000, 1, 1, 0),
            0, 32'h0, 0, 0);
    tab_add(mk_term(OP_RSVD5, 12'd4095, 12'd4095, 32'hFFFF_FFFF, 18'h3FFFF, 1, 1, 1),
            1, 32'h0, 0, 0);
    tab_add(mk_term(OP_RSVD6, 12'd3, 12'd4095, 32'h8000_0000, 18'h20000, 0, 1, 0),
            1, 32'h0, 0, 0);
    tab_add(mk_term(OP_RSVD7, 12'd4095, 12'd2, 32'h7FFF_FFFF, 18'h1FFFF, 1, 0, 1),
            1, 32'h0, 0, 0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    foreach (directed_tab[i])
      send_term(directed_tab[i].it, directed_tab[i].typed, directed_tab[i].res);

    // one long row runs the accumulator far past the q16.16 range before the row end clips
    send_term(mk_term(OP_WRITE, 12'd12, 12'd0, 32'h7FFF_FFFF, 18'h0, 0, 0, 0));
    send_term(mk_term(OP_DISTRIBUTE, 12'd13, 12'd12, 32'h7FFF_FFFF, 18'h1FFFF, 1, 0, 0));
    for (int unsigned k = 0; k < SAT_TERMS; k++)
      send_term(mk_term(OP_DISTRIBUTE, 12'd13, 12'd12, 32'h0, 18'h1FFFF, 0, 0, 0));
    send_term(mk_term(OP_DISTRIBUTE, 12'd13, 12'd12, 32'h0, 18'h1FFFF, 0, 1, 0));

    // spread written entries over the whole index range
    for (int unsigned k = 0; k < 48; k++)
      send_term(mk_term(OP_WRITE, any_index(), 12'd0, rand_q16(), 18'h0, 0, 0, 0));

    run_random_phase(175, 0, 0);
    run_random_phase(175, 73, 0);
    run_random_phase(175, 0, 73);
    run_random_phase(175, 7, 7);

    s_tvalid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_WAIT) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

[sim.f]
sv/scd_pkg.sv
sv/sparse_constraint_distribute_core.sv
sim/tb_top.sv
